// File: hw/rtl/mig_pkg.sv
`default_nettype none

package mig_pkg;

    // Number format: signed fixed point with FRAC_BITS fraction bits.
    localparam int VALUE_BITS  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int WIDE_BITS   = 2 * VALUE_BITS;
    localparam int DIV_STEPS   = VALUE_BITS + FRAC_BITS;

    // Size register.
    localparam int SIZE_BITS   = 4;
    localparam int SIZE_RESET  = 4;
    localparam int DEF_MAX_DIM = 8;

    typedef logic signed [VALUE_BITS-1:0] t_val;
    typedef logic signed [WIDE_BITS-1:0]  t_wide;

    localparam t_val VAL_MAX = t_val'({1'b0, {(VALUE_BITS-1){1'b1}}});
    localparam t_val VAL_MIN = t_val'({1'b1, {(VALUE_BITS-1){1'b0}}});
    localparam t_val Q_ONE   = t_val'(2 ** FRAC_BITS);

    // Clamp a wide signed value into the value range.
    function automatic t_val sat_val(input t_wide v);
        t_val res;
        if (v > t_wide'(VAL_MAX)) begin
            res = VAL_MAX;
        end else if (v < t_wide'(VAL_MIN)) begin
            res = VAL_MIN;
        end else begin
            res = t_val'(v[VALUE_BITS-1:0]);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/matrix_inverse_gauss_jordan_unit.sv
`default_nettype none

// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_ready      i_element_value, i_last_element
// output    out        o_out_valid / i_out_ready    o_inverse_value, o_status,
//                                                   o_last_result
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_matrix_size
//
// Elements load at one per cycle. The last element starts the inversion, during which
// no element is taken. A multiply-subtract is paced by the single read port of each
// store, and each division runs in the bit-serial divider.
// Reset is synchronous and needs no clearing pass. A stalled output holds the run.

module matrix_inverse_gauss_jordan_unit
    import mig_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic signed [VALUE_BITS-1:0] i_element_value,
    input  wire logic                 i_last_element,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic signed [VALUE_BITS-1:0] o_inverse_value,
    output logic                      o_status,
    output logic                      o_last_result,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [SIZE_BITS-1:0] i_cfg_matrix_size
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int LCW   = $clog2(DEPTH + 1);

    localparam logic SEL_SRC = 1'b0;
    localparam logic SEL_RES = 1'b1;

    localparam logic [4:0] ST_LOAD = 5'd0;
    localparam logic [4:0] ST_INIT = 5'd1;
    localparam logic [4:0] ST_PRD  = 5'd2;
    localparam logic [4:0] ST_PCK  = 5'd3;
    localparam logic [4:0] ST_SRD  = 5'd4;
    localparam logic [4:0] ST_SCK  = 5'd5;
    localparam logic [4:0] ST_W0   = 5'd6;
    localparam logic [4:0] ST_W1   = 5'd7;
    localparam logic [4:0] ST_W2   = 5'd8;
    localparam logic [4:0] ST_W3   = 5'd9;
    localparam logic [4:0] ST_ERD  = 5'd10;
    localparam logic [4:0] ST_EDV  = 5'd11;
    localparam logic [4:0] ST_EWT  = 5'd12;
    localparam logic [4:0] ST_RA   = 5'd13;
    localparam logic [4:0] ST_RB   = 5'd14;
    localparam logic [4:0] ST_RM   = 5'd15;
    localparam logic [4:0] ST_RW   = 5'd16;
    localparam logic [4:0] ST_NXI  = 5'd17;
    localparam logic [4:0] ST_AEN  = 5'd18;
    localparam logic [4:0] ST_APR  = 5'd19;
    localparam logic [4:0] ST_APK  = 5'd20;
    localparam logic [4:0] ST_FPR  = 5'd21;
    localparam logic [4:0] ST_FPK  = 5'd22;
    localparam logic [4:0] ST_FRD  = 5'd23;
    localparam logic [4:0] ST_FDV  = 5'd24;
    localparam logic [4:0] ST_FWT  = 5'd25;
    localparam logic [4:0] ST_ORD  = 5'd26;
    localparam logic [4:0] ST_OWT  = 5'd27;
    localparam logic [4:0] ST_SING = 5'd28;

    // Control registers.
    logic [4:0]           r_state, n_state;
    logic [SIZE_BITS-1:0] r_size, n_size;
    logic [LCW-1:0]       r_load, n_load;
    logic [DW-1:0]        r_n, n_n;
    logic [DW-1:0]        r_i, n_i;
    logic [DW-1:0]        r_j, n_j;
    logic [DW-1:0]        r_k, n_k;
    logic                 r_above, n_above;
    logic                 r_sel, n_sel;
    logic                 r_ovalid, n_ovalid;

    // Payload registers.
    t_val r_piv, n_piv;
    t_val r_mult, n_mult;
    t_val r_ta, n_ta;
    t_val r_tb, n_tb;
    t_val r_ovalue, n_ovalue;
    logic r_ostatus, n_ostatus;
    logic r_olast, n_olast;

    // Store ports.
    logic          s_we, d_we;
    logic [AW-1:0] s_waddr, wr_addr, rd_addr;
    t_val          s_wdata, d_wdata, s_rdata, d_rdata, sel_rdata;
    logic [DW-1:0] rd_row, rd_col, wr_row, wr_col;

    logic          div_start, div_done;
    t_val          div_num, div_quot, mac_res;

    logic [DW-1:0]      n1;
    logic [SIZE_BITS:0] size_ext;
    logic               in_xfer;

    function automatic logic [AW-1:0] mat_addr(input logic [DW-1:0] row,
                                               input logic [DW-1:0] col,
                                               input logic [DW-1:0] n);
        logic [2*DW-1:0] t;
        t = (2*DW)'(row) * (2*DW)'(n) + (2*DW)'(col);
        return t[AW-1:0];
    endfunction

    assign n1        = r_n - DW'(1);
    assign size_ext  = {1'b0, r_size};
    assign in_xfer   = i_in_valid && o_in_ready;
    assign rd_addr   = mat_addr(rd_row, rd_col, r_n);
    assign wr_addr   = mat_addr(wr_row, wr_col, r_n);
    assign sel_rdata = (r_sel == SEL_SRC) ? s_rdata : d_rdata;

    // Sequencer: load, identity fill, pivot search with row swap, elimination below and above, scaling, output.
    always_comb begin
        n_state   = r_state;
        n_size    = r_size;
        n_load    = r_load;
        n_n       = r_n;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_above   = r_above;
        n_sel     = r_sel;
        n_ovalid  = r_ovalid;
        n_piv     = r_piv;
        n_mult    = r_mult;
        n_ta      = r_ta;
        n_tb      = r_tb;
        n_ovalue  = r_ovalue;
        n_ostatus = r_ostatus;
        n_olast   = r_olast;
        s_we      = 1'b0;
        d_we      = 1'b0;
        s_waddr   = wr_addr;
        s_wdata   = mac_res;
        d_wdata   = mac_res;
        rd_row    = r_i;
        rd_col    = r_k;
        wr_row    = r_i;
        wr_col    = r_k;
        div_start = 1'b0;
        div_num   = s_rdata;

        if (o_out_valid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        if (i_cfg_valid) begin
            n_size = i_cfg_matrix_size;
        end

        unique case (r_state)
            ST_LOAD: begin
                if (in_xfer) begin
                    if (r_load < LCW'(DEPTH)) begin
                        s_we    = 1'b1;
                        s_waddr = r_load[AW-1:0];
                        s_wdata = i_element_value;
                        n_load  = r_load + LCW'(1);
                    end
                    if (i_last_element) begin
                        n_load = '0;
                        if (size_ext == '0) begin
                            n_n = DW'(1);
                        end else if (size_ext > (SIZE_BITS+1)'(MAX_DIM)) begin
                            n_n = DW'(MAX_DIM);
                        end else begin
                            n_n = DW'(size_ext);
                        end
                        n_i     = '0;
                        n_k     = '0;
                        n_state = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                d_we    = 1'b1;
                d_wdata = (r_i == r_k) ? Q_ONE : '0;
                if (r_k == n1) begin
                    n_k = '0;
                    if (r_i == n1) begin
                        n_i     = '0;
                        n_state = ST_PRD;
                    end else begin
                        n_i = r_i + DW'(1);
                    end
                end else begin
                    n_k = r_k + DW'(1);
                end
            end
            ST_PRD: begin
                rd_col  = r_i;
                n_state = ST_PCK;
            end
            ST_PCK: begin
                n_piv   = s_rdata;
                n_j     = r_i + DW'(1);
                n_above = 1'b0;
                if (s_rdata == '0) begin
                    n_state = (r_i == n1) ? ST_SING : ST_SRD;
                end else begin
                    n_state = (r_i == n1) ? ST_NXI : ST_ERD;
                end
            end
            ST_SRD: begin
                rd_row  = r_j;
                rd_col  = r_i;
                n_state = ST_SCK;
            end
            ST_SCK: begin
                if (s_rdata != '0) begin
                    n_k     = '0;
                    n_state = ST_W0;
                end else if (r_j == n1) begin
                    n_state = ST_SING;
                end else begin
                    n_j     = r_j + DW'(1);
                    n_state = ST_SRD;
                end
            end
            // Row swap in both stores, one column at a time.
            ST_W0: begin
                n_state = ST_W1;
            end
            ST_W1: begin
                rd_row  = r_j;
                n_ta    = s_rdata;
                n_tb    = d_rdata;
                n_state = ST_W2;
            end
            ST_W2: begin
                s_we    = 1'b1;
                d_we    = 1'b1;
                s_wdata = s_rdata;
                d_wdata = d_rdata;
                n_state = ST_W3;
            end
            ST_W3: begin
                wr_row  = r_j;
                s_we    = 1'b1;
                d_we    = 1'b1;
                s_wdata = r_ta;
                d_wdata = r_tb;
                if (r_k == n1) begin
                    n_state = ST_PRD;
                end else begin
                    n_k     = r_k + DW'(1);
                    n_state = ST_W0;
                end
            end
            // Multiplier for row j from its entry in the pivot column.
            ST_ERD: begin
                rd_row  = r_j;
                rd_col  = r_i;
                n_state = ST_EDV;
            end
            ST_EDV: begin
                div_start = 1'b1;
                n_state   = ST_EWT;
            end
            ST_EWT: begin
                if (div_done) begin
                    // The pivot-column entry of row j is cleared in the source store.
                    s_we    = 1'b1;
                    s_wdata = '0;
                    wr_row  = r_j;
                    wr_col  = r_i;
                    n_mult  = div_quot;
                    if (r_above) begin
                        n_sel = SEL_RES;
                        n_k   = '0;
                    end else begin
                        n_sel = SEL_SRC;
                        n_k   = r_i + DW'(1);
                    end
                    n_state = ST_RA;
                end
            end
            // Row update: row j minus row i times the multiplier.
            ST_RA: begin
                n_state = ST_RB;
            end
            ST_RB: begin
                rd_row  = r_j;
                n_ta    = sel_rdata;
                n_state = ST_RM;
            end
            ST_RM: begin
                n_tb    = sel_rdata;
                n_state = ST_RW;
            end
            ST_RW: begin
                wr_row = r_j;
                s_we   = (r_sel == SEL_SRC);
                d_we   = (r_sel == SEL_RES);
                if (r_k != n1) begin
                    n_k     = r_k + DW'(1);
                    n_state = ST_RA;
                end else if (!r_above) begin
                    if (r_sel == SEL_SRC) begin
                        n_sel   = SEL_RES;
                        n_k     = '0;
                        n_state = ST_RA;
                    end else if (r_j == n1) begin
                        n_state = ST_NXI;
                    end else begin
                        n_j     = r_j + DW'(1);
                        n_state = ST_ERD;
                    end
                end else if (r_j == '0) begin
                    if (r_i == DW'(1)) begin
                        n_i     = '0;
                        n_state = ST_FPR;
                    end else begin
                        n_i     = r_i - DW'(1);
                        n_state = ST_APR;
                    end
                end else begin
                    n_j     = r_j - DW'(1);
                    n_state = ST_ERD;
                end
            end
            ST_NXI: begin
                if (r_i == n1) begin
                    n_state = ST_AEN;
                end else begin
                    n_i     = r_i + DW'(1);
                    n_state = ST_PRD;
                end
            end
            // Elimination above the pivots, from the bottom row up.
            ST_AEN: begin
                n_above = 1'b1;
                if (n1 == '0) begin
                    n_i     = '0;
                    n_state = ST_FPR;
                end else begin
                    n_i     = n1;
                    n_state = ST_APR;
                end
            end
            ST_APR: begin
                rd_col  = r_i;
                n_state = ST_APK;
            end
            ST_APK: begin
                n_piv   = s_rdata;
                n_j     = r_i - DW'(1);
                n_state = ST_ERD;
            end
            // Scale each result row by its pivot.
            ST_FPR: begin
                rd_col  = r_i;
                n_state = ST_FPK;
            end
            ST_FPK: begin
                n_piv   = s_rdata;
                n_k     = '0;
                n_state = ST_FRD;
            end
            ST_FRD: begin
                n_state = ST_FDV;
            end
            ST_FDV: begin
                div_start = 1'b1;
                div_num   = d_rdata;
                n_state   = ST_FWT;
            end
            ST_FWT: begin
                if (div_done) begin
                    d_we    = 1'b1;
                    d_wdata = div_quot;
                    if (r_k == n1) begin
                        n_k = '0;
                        if (r_i == n1) begin
                            n_i     = '0;
                            n_state = ST_ORD;
                        end else begin
                            n_i     = r_i + DW'(1);
                            n_state = ST_FPR;
                        end
                    end else begin
                        n_k     = r_k + DW'(1);
                        n_state = ST_FRD;
                    end
                end
            end
            // Output of the inverse, row-major.
            ST_ORD: begin
                if (!r_ovalid) begin
                    n_state = ST_OWT;
                end
            end
            ST_OWT: begin
                n_ovalid  = 1'b1;
                n_ovalue  = d_rdata;
                n_ostatus = 1'b0;
                n_olast   = (r_i == n1) && (r_k == n1);
                if (r_k == n1) begin
                    n_k = '0;
                    if (r_i == n1) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_i     = r_i + DW'(1);
                        n_state = ST_ORD;
                    end
                end else begin
                    n_k     = r_k + DW'(1);
                    n_state = ST_ORD;
                end
            end
            ST_SING: begin
                if (!r_ovalid) begin
                    n_ovalid  = 1'b1;
                    n_ovalue  = '0;
                    n_ostatus = 1'b1;
                    n_olast   = 1'b1;
                    n_state   = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_size   <= SIZE_BITS'(SIZE_RESET);
            r_load   <= '0;
            r_n      <= DW'(1);
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_above  <= 1'b0;
            r_sel    <= SEL_SRC;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_size   <= n_size;
            r_load   <= n_load;
            r_n      <= n_n;
            r_i      <= n_i;
            r_j      <= n_j;
            r_k      <= n_k;
            r_above  <= n_above;
            r_sel    <= n_sel;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload state.
    always_ff @(posedge i_clk) begin
        r_piv     <= n_piv;
        r_mult    <= n_mult;
        r_ta      <= n_ta;
        r_tb      <= n_tb;
        r_ovalue  <= n_ovalue;
        r_ostatus <= n_ostatus;
        r_olast   <= n_olast;
    end

    mig_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_src (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (rd_addr),
        .o_rdata (s_rdata)
    );

    mig_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_res (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (wr_addr),
        .i_wdata (d_wdata),
        .i_raddr (rd_addr),
        .o_rdata (d_rdata)
    );

    mig_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_piv),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    mig_mac u_mac (
        .i_clk (i_clk),
        .i_a   (r_ta),
        .i_b   (r_mult),
        .i_c   (r_tb),
        .o_res (mac_res)
    );

    assign o_in_ready      = (r_state == ST_LOAD);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_ovalid;
    assign o_inverse_value = r_ovalue;
    assign o_status        = r_ostatus;
    assign o_last_result   = r_olast;

endmodule

`default_nettype wire

// File: hw/rtl/mig_ram.sv
`default_nettype none

module mig_ram #(
    parameter int WIDTH     = 32,
    parameter int DEPTH     = 64,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [ADDR_BITS-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]     i_wdata,
    input  wire logic [ADDR_BITS-1:0] i_raddr,
    output logic      [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/mig_div.sv
`default_nettype none

module mig_div
    import mig_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_val i_num,
    input  wire t_val i_den,
    output logic      o_done,
    output t_val      o_quot
);

    localparam int CW = $clog2(DIV_STEPS);

    logic                  r_busy;
    logic                  r_fin;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [DIV_STEPS-1:0]  r_num;
    logic [DIV_STEPS-1:0]  r_quo;
    logic [VALUE_BITS-1:0] r_rem;
    logic [VALUE_BITS-1:0] r_den;
    logic                  r_neg;
    logic                  r_zero;
    t_val                  r_res;

    logic [VALUE_BITS-1:0] mag_num;
    logic [VALUE_BITS-1:0] mag_den;
    logic [VALUE_BITS:0]   trial;
    logic                  fits;
    logic [VALUE_BITS-1:0] rem_nx;
    logic [DIV_STEPS-1:0]  pos_lim;
    t_val                  res_nx;

    // Operand magnitudes; the dividend is scaled by the fraction width.
    assign mag_num = i_num[VALUE_BITS-1] ? (~unsigned'(i_num)) + VALUE_BITS'(1)
                                         : unsigned'(i_num);
    assign mag_den = i_den[VALUE_BITS-1] ? (~unsigned'(i_den)) + VALUE_BITS'(1)
                                         : unsigned'(i_den);

    // One restoring step per cycle.
    assign trial  = {r_rem, r_num[DIV_STEPS-1]};
    assign fits   = trial >= {1'b0, r_den};
    assign rem_nx = fits ? VALUE_BITS'(trial - {1'b0, r_den}) : trial[VALUE_BITS-1:0];

    // Sign and saturation of the finished quotient; a zero divisor gives zero.
    assign pos_lim = DIV_STEPS'(unsigned'(VAL_MAX));
    always_comb begin
        if (r_zero) begin
            res_nx = '0;
        end else if (r_neg) begin
            if (r_quo > pos_lim + DIV_STEPS'(1)) begin
                res_nx = VAL_MIN;
            end else begin
                res_nx = t_val'((~r_quo[VALUE_BITS-1:0]) + VALUE_BITS'(1));
            end
        end else if (r_quo > pos_lim) begin
            res_nx = VAL_MAX;
        end else begin
            res_nx = t_val'(r_quo[VALUE_BITS-1:0]);
        end
    end

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CW'(DIV_STEPS - 1))) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b1;
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= '0;
            r_num  <= {mag_num, {FRAC_BITS{1'b0}}};
            r_den  <= mag_den;
            r_rem  <= '0;
            r_quo  <= '0;
            r_neg  <= i_num[VALUE_BITS-1] ^ i_den[VALUE_BITS-1];
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            r_num <= {r_num[DIV_STEPS-2:0], 1'b0};
            r_rem <= rem_nx;
            r_quo <= {r_quo[DIV_STEPS-2:0], fits};
        end
        if (r_fin) begin
            r_res <= res_nx;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_res;

endmodule

`default_nettype wire

// File: hw/rtl/mig_mac.sv
`default_nettype none

module mig_mac
    import mig_pkg::*;
(
    input  wire logic i_clk,
    input  wire t_val i_a,
    input  wire t_val i_b,
    input  wire t_val i_c,
    output t_val      o_res
);

    t_wide r_prod;
    t_wide floored;
    t_val  prod_q;
    t_wide diff;

    // Full product, registered.
    always_ff @(posedge i_clk) begin
        r_prod <= t_wide'(i_a) * t_wide'(i_b);
    end

    // Floor to the fixed-point scale, saturate, subtract from the target, saturate.
    assign floored = r_prod >>> FRAC_BITS;
    assign prod_q  = sat_val(floored);
    assign diff    = t_wide'(i_c) - t_wide'(prod_q);
    assign o_res   = sat_val(diff);

endmodule

`default_nettype wire
